/* src/i2c_register_access_master_macros.svh */
// ----------------------------------------------------------------------------
// I2C register access master assertion macros
// Clocked assertion helpers for the RTL file that checks itself (i2cra_seq).
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// check a property on every clock edge out of reset
`define I2CRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition is followed in the next cycle by another
`define I2CRA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* src/i2cra_pkg.sv */
// ----------------------------------------------------------------------------
// I2C register access master package
// Payload types, opcodes, register indexes and shared helpers.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  localparam int CMD_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam int CFG_AW = 3;

  localparam logic [7:0] DEV_ADDR_RST = 8'd144;
  localparam logic [9:0] GAP_RST      = 10'd50;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_IDX_DEV_ADDR = 1'b0;
  localparam logic CFG_IDX_GAP      = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic [15:0] read_data;
    logic        read_done;
    logic        request_dropped;
  } out_item_t;

  typedef struct packed {
    logic        req_wr;
    logic        req_rd;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        sda_in;
  } cmd_t;

  function automatic logic [7:0] byte_to_send(input logic [2:0]  idx,
                                              input logic [7:0]  dev,
                                              input logic [7:0]  regnum,
                                              input logic [15:0] val,
                                              input logic        rd);
    logic [7:0] b;
    if (idx == 3'd0) begin
      b = dev;
    end else if (idx == 3'd1) begin
      b = regnum;
    end else if (rd) begin
      b = dev | 8'h01;
    end else if (idx == 3'd2) begin
      b = val[15:8];
    end else begin
      b = val[7:0];
    end
    return b;
  endfunction

endpackage

/* src/i2c_register_access_master.sv */
// A tick passes the front register and the command FIFO, and its result the
// result FIFO. One tick per cycle unless a FIFO is full; one bus step per tick.
// The front stage and the command and result FIFOs decouple both sides.
// Reset (synchronous, rst_n low): bus idle, FIFOs empty, registers at 144 and 50.
// ----------------------------------------------------------------------------
// I2C register access master
// Tick-driven I2C master for 16-bit register writes and reads with APB setup.
// ----------------------------------------------------------------------------
module i2c_register_access_master
  import i2cra_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  in_item_t          in_data,
  output logic              in_full,
  input  logic              out_pop,
  output out_item_t         out_data,
  output logic              out_empty,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0] dev_addr_r;
  logic [9:0] gap_ticks_r;
  logic       cfg_wr;

  logic       f_push, f_full;
  cmd_t       f_data, q_data;
  logic       q_empty, q_pop;
  logic       r_push, r_full;
  out_item_t  r_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      gap_ticks_r <= GAP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_IDX_DEV_ADDR: dev_addr_r  <= pwdata[7:0];
        CFG_IDX_GAP:      gap_ticks_r <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_DEV_ADDR: prdata = {24'd0, dev_addr_r};
      CFG_IDX_GAP:      prdata = {22'd0, gap_ticks_r};
    endcase
  end

  i2cra_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_push (f_push),
    .cmd_data (f_data),
    .cmd_full (f_full)
  );

  i2cra_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_data),
    .full  (f_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  i2cra_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_addr  (dev_addr_r),
    .gap_ticks (gap_ticks_r),
    .cmd       (q_data),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res_push  (r_push),
    .res       (r_data),
    .res_full  (r_full)
  );

  i2cra_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata (r_data),
    .full  (r_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

/* src/i2cra_fifo.sv */
// ----------------------------------------------------------------------------
// I2C register access master FIFO
// Small register FIFO with full and empty flags, first word on rdata.
// ----------------------------------------------------------------------------
module i2cra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* src/i2cra_front.sv */
// ----------------------------------------------------------------------------
// I2C register access master front end
// Accept tick transactions, decode the request code and hand them on.
// ----------------------------------------------------------------------------
module i2cra_front
  import i2cra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_data,
  output logic     in_full,
  output logic     cmd_push,
  output cmd_t     cmd_data,
  input  logic     cmd_full
);

  logic valid_r;
  cmd_t cmd_r;
  logic take;

  assign in_full  = valid_r && cmd_full;
  assign take     = in_push && !in_full;
  assign cmd_push = valid_r;
  assign cmd_data = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!cmd_full) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r.req_wr     <= (in_data.op == OP_WRITE);
      cmd_r.req_rd     <= (in_data.op == OP_READ);
      cmd_r.reg_addr   <= in_data.reg_addr;
      cmd_r.write_data <= in_data.write_data;
      cmd_r.sda_in     <= in_data.sda_in;
    end
  end

endmodule

/* src/i2cra_seq.sv */
// ----------------------------------------------------------------------------
// I2C register access master bus sequencer
// Advance the bus phase one tick per transaction and emit line levels.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_macros.svh"

module i2cra_seq
  import i2cra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] dev_addr,
  input  logic [9:0] gap_ticks,
  input  cmd_t       cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  output logic       res_push,
  output out_item_t  res,
  input  logic       res_full
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_WBIT, PH_WACK, PH_RBIT, PH_MACK, PH_STOP, PH_GAP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  lreg_r, lreg_nxt;
  logic [15:0] lval_r, lval_nxt;
  logic        rd_r, rd_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [9:0]  gap_r, gap_nxt;
  logic        step;

  assign step     = !cmd_empty && !res_full;
  assign cmd_pop  = step;
  assign res_push = step;

  always_comb begin
    logic req;
    logic scl, so, drv, busy, done, drop;
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    bit_nxt   = bit_r;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    lreg_nxt  = lreg_r;
    lval_nxt  = lval_r;
    rd_nxt    = rd_r;
    hold_nxt  = hold_r;
    gap_nxt   = gap_r;
    req  = cmd.req_wr || cmd.req_rd;
    drop = 1'b0;
    scl  = 1'b1;
    so   = 1'b1;
    drv  = 1'b1;
    busy = 1'b1;
    done = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (req) begin
        lreg_nxt  = cmd.reg_addr;
        lval_nxt  = cmd.req_wr ? cmd.write_data : 16'd0;
        rd_nxt    = cmd.req_rd;
        byte_nxt  = 3'd0;
        step_nxt  = 2'd0;
        phase_nxt = PH_START;
      end
    end else begin
      drop = req;
    end

    unique case (phase_nxt)
      PH_START: begin
        scl = (step_nxt < 2'd2);
        so  = (step_nxt == 2'd0);
        if (step_nxt < 2'd2) begin
          step_nxt = step_nxt + 1'b1;
        end else begin
          shift_nxt = byte_to_send(byte_nxt, dev_addr, lreg_nxt, lval_nxt, rd_nxt);
          bit_nxt   = 3'd7;
          step_nxt  = 2'd0;
          phase_nxt = PH_WBIT;
        end
      end
      PH_WBIT: begin
        scl = (step_nxt == 2'd1);
        so  = shift_nxt[bit_nxt];
        if (step_nxt < 2'd2) begin
          step_nxt = step_nxt + 1'b1;
        end else begin
          step_nxt = 2'd0;
          if (bit_nxt == 3'd0) begin
            phase_nxt = PH_WACK;
          end else begin
            bit_nxt = bit_nxt - 1'b1;
          end
        end
      end
      PH_WACK: begin
        scl = (step_nxt == 2'd1);
        so  = 1'b1;
        if (step_nxt < 2'd2) begin
          step_nxt = step_nxt + 1'b1;
        end else begin
          step_nxt = 2'd0;
          byte_nxt = byte_nxt + 1'b1;
          if ((!rd_nxt && byte_nxt >= 3'd4) || (rd_nxt && byte_nxt >= 3'd3)) begin
            if (rd_nxt) begin
              shift_nxt = 8'd0;
              bit_nxt   = 3'd7;
              phase_nxt = PH_RBIT;
            end else begin
              phase_nxt = PH_STOP;
            end
          end else if (rd_nxt && byte_nxt == 3'd2) begin
            phase_nxt = PH_START;
          end else begin
            shift_nxt = byte_to_send(byte_nxt, dev_addr, lreg_nxt, lval_nxt, rd_nxt);
            bit_nxt   = 3'd7;
            phase_nxt = PH_WBIT;
          end
        end
      end
      PH_RBIT: begin
        drv = 1'b0;
        so  = 1'b1;
        if (step_nxt == 2'd0) begin
          scl       = 1'b1;
          shift_nxt = {shift_nxt[6:0], cmd.sda_in};
          step_nxt  = 2'd1;
        end else begin
          scl      = 1'b0;
          step_nxt = 2'd0;
          if (bit_nxt == 3'd0) begin
            phase_nxt = PH_MACK;
          end else begin
            bit_nxt = bit_nxt - 1'b1;
          end
        end
      end
      PH_MACK: begin
        scl = (step_nxt == 2'd1);
        so  = (step_nxt == 2'd2) ? 1'b1 : (byte_nxt != 3'd3);
        if (step_nxt < 2'd2) begin
          step_nxt = step_nxt + 1'b1;
        end else begin
          step_nxt = 2'd0;
          lval_nxt = {lval_nxt[7:0], shift_nxt};
          byte_nxt = byte_nxt + 1'b1;
          if (byte_nxt >= 3'd5) begin
            phase_nxt = PH_STOP;
          end else begin
            shift_nxt = 8'd0;
            bit_nxt   = 3'd7;
            phase_nxt = PH_RBIT;
          end
        end
      end
      PH_STOP: begin
        scl = (step_nxt != 2'd0);
        so  = (step_nxt == 2'd2);
        if (step_nxt < 2'd2) begin
          step_nxt = step_nxt + 1'b1;
        end else begin
          step_nxt = 2'd0;
          if (rd_nxt) begin
            hold_nxt  = lval_nxt;
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (gap_ticks == 10'd0) begin
            phase_nxt = PH_IDLE;
          end else begin
            gap_nxt   = gap_ticks;
            phase_nxt = PH_GAP;
          end
        end
      end
      PH_GAP: begin
        if (gap_nxt != 10'd0) begin
          gap_nxt = gap_nxt - 1'b1;
        end
        if (gap_nxt == 10'd0) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_IDLE: begin
        busy = 1'b0;
      end
    endcase

    res.scl             = scl;
    res.sda_out         = so;
    res.sda_drive       = drv;
    res.busy_res        = busy;
    res.read_data       = hold_nxt;
    res.read_done       = done;
    res.request_dropped = drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      byte_r  <= '0;
      bit_r   <= '0;
      step_r  <= '0;
      shift_r <= '0;
      lreg_r  <= '0;
      lval_r  <= '0;
      rd_r    <= 1'b0;
      hold_r  <= '0;
      gap_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      byte_r  <= byte_nxt;
      bit_r   <= bit_nxt;
      step_r  <= step_nxt;
      shift_r <= shift_nxt;
      lreg_r  <= lreg_nxt;
      lval_r  <= lval_nxt;
      rd_r    <= rd_nxt;
      hold_r  <= hold_nxt;
      gap_r   <= gap_nxt;
    end
  end

  `I2CRA_ASSERT(a_done_in_stop, (step && res.read_done) |-> (phase_r == PH_STOP && rd_r), "read_done outside read stop")
  `I2CRA_ASSERT(a_undriven_rbit, (step && !res.sda_drive) |-> (phase_r == PH_RBIT), "SDA released outside read bit")
  `I2CRA_ASSERT_NEXT(a_gap_end, step && phase_r == PH_GAP && gap_r == 10'd1, phase_r == PH_IDLE, "gap did not end")
  `I2CRA_ASSERT_NEXT(a_hold_stall, !step, $stable(phase_r) && $stable(step_r), "state moved without a transaction")

endmodule

/* sim/i2cra_bus_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master bus-level checker
// Watches the tick, result and APB channels. Predicts the SCL/SDA levels, busy,
// read value, done and drop flags of every accepted tick and compares each popped
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module i2cra_bus_checker
  import i2cra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  in_item_t          in_data,
  input  logic              out_pop,
  input  logic              out_empty,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                errors,
  output int                pending,
  output int                n_ticks,
  output int                n_writes,
  output int                n_reads,
  output int                n_reads_done,
  output int                n_dropped
);

  typedef enum logic [4:0] {
    BUS_IDLE,
    BUS_START,
    BUS_WBIT,
    BUS_WACK,
    BUS_RBIT,
    BUS_MACK,
    BUS_STOP,
    BUS_GAP
  } bus_ph_e;

  logic [7:0]  dev_addr;
  logic [9:0]  gap_len;

  bus_ph_e     bus_ph;
  logic [2:0]  byte_idx;
  logic [3:0]  bit_idx;
  logic [1:0]  bit_stp;
  logic [7:0]  shreg;
  logic [7:0]  reg_lat;
  logic [15:0] val_lat;
  logic        rd_mode;
  logic [15:0] rd_hold;
  logic [9:0]  gap_cnt;

  out_item_t   expected_levels[$];

  initial begin
    errors       = 0;
    pending      = 0;
    n_ticks      = 0;
    n_writes     = 0;
    n_reads      = 0;
    n_reads_done = 0;
    n_dropped    = 0;
  end

  task automatic clear_bus_state();
    dev_addr = DEV_ADDR_RST;
    gap_len  = GAP_RST;
    bus_ph   = BUS_IDLE;
    byte_idx = '0;
    bit_idx  = '0;
    bit_stp  = '0;
    shreg    = '0;
    reg_lat  = '0;
    val_lat  = '0;
    rd_mode  = 1'b0;
    rd_hold  = '0;
    gap_cnt  = '0;
  endtask

  task automatic load_tx_byte();
    if (byte_idx == 3'd0) begin
      shreg = dev_addr;
    end else if (byte_idx == 3'd1) begin
      shreg = reg_lat;
    end else if (rd_mode) begin
      shreg = dev_addr | 8'h01;
    end else if (byte_idx == 3'd2) begin
      shreg = val_lat[15:8];
    end else begin
      shreg = val_lat[7:0];
    end
    bit_idx = 4'd7;
    bit_stp = 2'd0;
    bus_ph  = BUS_WBIT;
  endtask

  task automatic load_rx_byte();
    shreg   = 8'h00;
    bit_idx = 4'd7;
    bit_stp = 2'd0;
    bus_ph  = BUS_RBIT;
  endtask

  task automatic predict_bus_tick(input in_item_t t, output out_item_t r);
    logic req;
    req = (t.op == OP_WRITE) || (t.op == OP_READ);
    r = '0;
    r.scl       = 1'b1;
    r.sda_out   = 1'b1;
    r.sda_drive = 1'b1;
    r.busy_res  = 1'b1;

    if (bus_ph == BUS_IDLE) begin
      if (req) begin
        reg_lat  = t.reg_addr;
        val_lat  = (t.op == OP_WRITE) ? t.write_data : 16'h0000;
        rd_mode  = (t.op == OP_READ);
        byte_idx = 3'd0;
        bit_stp  = 2'd0;
        bus_ph   = BUS_START;
        if (rd_mode) n_reads++;
        else n_writes++;
      end
    end else if (req) begin
      r.request_dropped = 1'b1;
      n_dropped++;
    end

    case (bus_ph)
      BUS_START: begin
        r.scl     = (bit_stp < 2'd2);
        r.sda_out = (bit_stp == 2'd0);
        if (bit_stp < 2'd2) bit_stp++;
        else load_tx_byte();
      end
      BUS_WBIT: begin
        r.scl     = (bit_stp == 2'd1);
        r.sda_out = shreg[bit_idx[2:0]];
        if (bit_stp < 2'd2) begin
          bit_stp++;
        end else begin
          bit_stp = 2'd0;
          if (bit_idx == 4'd0) bus_ph = BUS_WACK;
          else bit_idx--;
        end
      end
      BUS_WACK: begin
        r.scl     = (bit_stp == 2'd1);
        r.sda_out = 1'b1;
        if (bit_stp < 2'd2) begin
          bit_stp++;
        end else begin
          bit_stp = 2'd0;
          byte_idx++;
          if (!rd_mode) begin
            if (byte_idx >= 3'd4) bus_ph = BUS_STOP;
            else load_tx_byte();
          end else if (byte_idx == 3'd2) begin
            bus_ph = BUS_START;
          end else if (byte_idx >= 3'd3) begin
            load_rx_byte();
          end else begin
            load_tx_byte();
          end
        end
      end
      BUS_RBIT: begin
        r.sda_drive = 1'b0;
        r.sda_out   = 1'b1;
        if (bit_stp == 2'd0) begin
          r.scl   = 1'b1;
          shreg   = {shreg[6:0], t.sda_in};
          bit_stp = 2'd1;
        end else begin
          r.scl   = 1'b0;
          bit_stp = 2'd0;
          if (bit_idx == 4'd0) bus_ph = BUS_MACK;
          else bit_idx--;
        end
      end
      BUS_MACK: begin
        r.scl     = (bit_stp == 2'd1);
        r.sda_out = (bit_stp == 2'd2) ? 1'b1 : (byte_idx != 3'd3);
        if (bit_stp < 2'd2) begin
          bit_stp++;
        end else begin
          bit_stp = 2'd0;
          val_lat = {val_lat[7:0], shreg};
          byte_idx++;
          if (byte_idx >= 3'd5) bus_ph = BUS_STOP;
          else load_rx_byte();
        end
      end
      BUS_STOP: begin
        r.scl     = (bit_stp != 2'd0);
        r.sda_out = (bit_stp == 2'd2);
        if (bit_stp < 2'd2) begin
          bit_stp++;
        end else begin
          bit_stp = 2'd0;
          if (rd_mode) begin
            rd_hold     = val_lat;
            r.read_done = 1'b1;
            bus_ph      = BUS_IDLE;
            n_reads_done++;
          end else if (gap_len == 10'd0) begin
            bus_ph = BUS_IDLE;
          end else begin
            gap_cnt = gap_len;
            bus_ph  = BUS_GAP;
          end
        end
      end
      BUS_GAP: begin
        if (gap_cnt > 10'd0) gap_cnt--;
        if (gap_cnt == 10'd0) bus_ph = BUS_IDLE;
      end
      default: begin
        r.busy_res = 1'b0;
        bus_ph     = BUS_IDLE;
      end
    endcase

    r.read_data = rd_hold;
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      clear_bus_state();
      expected_levels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          CFG_IDX_DEV_ADDR: dev_addr = pwdata[7:0];
          CFG_IDX_GAP:      gap_len  = pwdata[9:0];
        endcase
      end
      if (in_push && !in_full) begin
        predict_bus_tick(in_data, want);
        expected_levels.push_back(want);
        n_ticks++;
      end
      if (out_pop && !out_empty) begin
        got = out_data;
        if (expected_levels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("[%0t] unexpected transaction on result port", $time);
        end else begin
          want = expected_levels.pop_front();
          if (got.scl !== want.scl || got.sda_out !== want.sda_out ||
              got.sda_drive !== want.sda_drive || got.busy_res !== want.busy_res ||
              got.read_data !== want.read_data || got.read_done !== want.read_done ||
              got.request_dropped !== want.request_dropped) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] mismatch exp scl=%b sda=%b drv=%b busy=%b rd=%h done=%b drop=%b",
                       $time, want.scl, want.sda_out, want.sda_drive, want.busy_res,
                       want.read_data, want.read_done, want.request_dropped);
              $display("[%0t]          got scl=%b sda=%b drv=%b busy=%b rd=%h done=%b drop=%b",
                       $time, got.scl, got.sda_out, got.sda_drive, got.busy_res,
                       got.read_data, got.read_done, got.request_dropped);
            end
          end
        end
      end
    end
    pending = expected_levels.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master testbench
// Drives bus ticks carrying register write and read requests with random
// idling on both channels, reprograms the device address and write gap
// between phases over APB, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import i2cra_pkg::*;

  localparam int         PHASES         = 6;
  localparam int         PHASE_TICKS    = 27;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] OP_UNUSED      = 2'd3;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              in_push = 1'b0;
  in_item_t          in_data = '0;
  logic              in_full;
  logic              out_pop = 1'b0;
  out_item_t         out_data;
  logic              out_empty;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic gaps_on = 1'b1;
  int   quiet_cycles = 0;
  int   errors, pending, n_ticks, n_writes, n_reads, n_reads_done, n_dropped;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  i2c_register_access_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  i2cra_bus_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data      (in_data),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_data     (out_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .errors       (errors),
    .pending      (pending),
    .n_ticks      (n_ticks),
    .n_writes     (n_writes),
    .n_reads      (n_reads),
    .n_reads_done (n_reads_done),
    .n_dropped    (n_dropped)
  );

  always @(posedge clk) begin
    out_pop <= !gaps_on || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_tick(input logic [1:0] op, input logic [7:0] ra,
                                         input logic [15:0] wd, input int sda_lvl);
    in_item_t t;
    t.op         = op;
    t.reg_addr   = ra;
    t.write_data = wd;
    t.sda_in     = (sda_lvl < 0) ? 1'($urandom_range(1)) : 1'(sda_lvl);
    return t;
  endfunction

  function automatic in_item_t rand_tick();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(99);
    if (pick < 3) op = OP_WRITE;
    else if (pick < 6) op = OP_READ;
    else if (pick < 8) op = OP_UNUSED;
    else op = OP_TICK;
    return make_tick(op, 8'($urandom_range(255)), 16'($urandom_range(65535)), -1);
  endfunction

  task automatic send_tick(input in_item_t t);
    logic taken;
    while (gaps_on && $urandom_range(99) < 27) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= t;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
    end
  endtask

  task automatic fill_ticks(input int n, input int sda_lvl);
    for (int i = 0; i < n; i++) begin
      send_tick(make_tick(OP_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                          sda_lvl));
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] dev, input logic [9:0] gap);
    cfg_write(CFG_IDX_DEV_ADDR, {24'h0, dev});
    cfg_write(CFG_IDX_GAP, {22'h0, gap});
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: all-ones write, then requests while busy
    send_tick(make_tick(OP_WRITE, 8'hFF, 16'hFFFF, 1));
    send_tick(make_tick(OP_READ, 8'h00, 16'h0000, 0));
    send_tick(make_tick(OP_UNUSED, 8'h00, 16'h0000, 0));
    send_tick(make_tick(OP_WRITE, 8'h12, 16'h3456, 1));
    fill_ticks(170, -1);
    send_tick(make_tick(OP_UNUSED, 8'hFF, 16'hFFFF, 1));
    send_tick(make_tick(OP_READ, 8'hA5, 16'hFFFF, 1));
    fill_ticks(40, 1);
    // change the address while the read is still before its repeated start
    wait_drained();
    cfg_write(CFG_IDX_DEV_ADDR, 32'd254);
    fill_ticks(100, 1);

    // zero gap: a read right after the write's stop is accepted
    wait_drained();
    set_config(8'd0, 10'd0);
    send_tick(make_tick(OP_WRITE, 8'h00, 16'h0000, 0));
    fill_ticks(113, 0);
    send_tick(make_tick(OP_READ, 8'h5A, 16'h0000, 0));
    fill_ticks(130, 0);
    send_tick(make_tick(OP_READ, 8'hC3, 16'h0000, 1));
    fill_ticks(130, -1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       set_config(8'd1, 10'd1023);
        1:       set_config(8'($urandom_range(254)), 10'd0);
        default: set_config(8'($urandom_range(254)), 10'($urandom_range(7)));
      endcase
      gaps_on <= (ph != 3);
      @(posedge clk);
      for (int k = 0; k < PHASE_TICKS * 2; k++) begin
        if (ph == 5 && k == PHASE_TICKS) wait_drained();
        send_tick(rand_tick());
      end
    end

    wait_drained();
    $display("Covered %0d ticks: %0d writes and %0d reads started, %0d reads done,",
             n_ticks, n_writes, n_reads, n_reads_done);
    $display("%0d requests dropped while busy, %0d mismatches.", n_dropped, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
